>>> hdl/stream_duplicate_remover_core_defines.svh
// Assertion macros shared by the duplicate remover.
`ifndef STREAM_DUPLICATE_REMOVER_CORE_DEFINES_SVH
`define STREAM_DUPLICATE_REMOVER_CORE_DEFINES_SVH

// Implication checked at every rising clock edge outside reset.
`define SDR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("duplicate remover implication check failed");

// Condition that must hold at every rising clock edge outside reset.
`define SDR_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("duplicate remover invariant check failed");

`endif

>>> hdl/sdr_pkg.sv
`timescale 1ns / 1ps

package sdr_pkg;

    localparam int VALUE_W         = 32;
    localparam int COUNT_W         = 8;
    localparam int MAX_ENTRIES_DEF = 128;

    localparam logic KIND_NEW = 1'b0;
    localparam logic KIND_END = 1'b1;

    // Outcome of a search as it walks down the row of cells.
    typedef enum logic [1:0] {
        ST_SEARCH,
        ST_NEW,
        ST_DUP
    } t_status;

    typedef struct packed {
        logic                      vld;
        t_status                   st;
        logic signed [VALUE_W-1:0] val;
    } t_token;

endpackage

>>> hdl/sdr_cell.sv
`timescale 1ns / 1ps

module sdr_cell #(
    parameter int CELL_IDX = 0,
    parameter int IDX_W    = 7,
    parameter int CNT_W    = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [CNT_W-1:0]   i_count,
    input  sdr_pkg::t_token    i_tok,
    input  logic [IDX_W-1:0]   i_pos,
    output sdr_pkg::t_token    o_tok,
    output logic [IDX_W-1:0]   o_pos
);

    localparam logic [CNT_W-1:0] IdxCnt = CNT_W'(CELL_IDX);
    localparam logic [IDX_W-1:0] IdxPos = IDX_W'(CELL_IDX);

    logic signed [sdr_pkg::VALUE_W-1:0] r_entry;
    sdr_pkg::t_token                    r_tok;
    sdr_pkg::t_token                    n_tok;
    logic [IDX_W-1:0]                   r_pos;
    logic [IDX_W-1:0]                   n_pos;
    logic                               w_occupied;
    logic                               w_store;

    // The entry holds a value of the current list only below the kept count.
    assign w_occupied = (IdxCnt < i_count);

    always_comb begin
        n_tok   = i_tok;
        n_pos   = i_pos;
        w_store = 1'b0;
        if (i_tok.vld && (i_tok.st == sdr_pkg::ST_SEARCH)) begin
            if (w_occupied) begin
                if (r_entry == i_tok.val) begin
                    n_tok.st = sdr_pkg::ST_DUP;
                end
            end else begin
                w_store  = 1'b1;
                n_tok.st = sdr_pkg::ST_NEW;
                n_pos    = IdxPos;
            end
        end
    end

    // Only the valid bit is reset; the payload is qualified by it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok.vld <= n_tok.vld;
        end
        r_tok.st  <= n_tok.st;
        r_tok.val <= n_tok.val;
        r_pos     <= n_pos;
        if (w_store) begin
            r_entry <= i_tok.val;
        end
    end

    assign o_tok = r_tok;
    assign o_pos = r_pos;

endmodule

>>> hdl/stream_duplicate_remover_core.sv
`timescale 1ns / 1ps
// Channel  Handshake                   Payload
// input    i_in_valid / o_in_ready     i_value
// output   o_out_valid / i_out_ready   o_kind, o_value_res, o_count, o_overflow
//
// A zero request's end-of-list result is loaded into the output register at acceptance.
// A nonzero request walks the whole row of MAX_ENTRIES cells, one cell per cycle,
// and the block stays busy until the search leaves the last cell.
// Reset (i_rst_n low, synchronous) empties the list and the output register.
// A request is taken only when no search is in flight and the output register is
// empty or is being drained in the same cycle.

`include "stream_duplicate_remover_core_defines.svh"

module stream_duplicate_remover_core #(
    parameter int MAX_ENTRIES = sdr_pkg::MAX_ENTRIES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [sdr_pkg::VALUE_W-1:0] i_value,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_kind,
    output logic signed [sdr_pkg::VALUE_W-1:0] o_value_res,
    output logic [sdr_pkg::COUNT_W-1:0]        o_count,
    output logic                               o_overflow
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_ENTRIES);

    // List state: the number of entries kept and whether a value was dropped.
    logic [CNT_W-1:0] r_count;
    logic             r_ovf;
    logic             r_busy;

    // Output register.
    logic                               r_out_vld;
    logic                               r_kind;
    logic signed [sdr_pkg::VALUE_W-1:0] r_value_res;
    logic [sdr_pkg::COUNT_W-1:0]        r_count_out;
    logic                               r_ovf_out;

    logic w_in_acc;
    logic w_out_acc;
    logic w_is_end;
    logic w_exit_new;

    // The token chain: link k feeds cell k, link MAX_ENTRIES leaves the last cell.
    sdr_pkg::t_token  w_tok [MAX_ENTRIES+1];
    logic [IDX_W-1:0] w_pos [MAX_ENTRIES+1];

    assign o_in_ready = !r_busy && (!r_out_vld || i_out_ready);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_acc  = r_out_vld && i_out_ready;
    assign w_is_end   = (i_value == '0);
    assign w_exit_new = w_tok[MAX_ENTRIES].vld && (w_tok[MAX_ENTRIES].st == sdr_pkg::ST_NEW);

    // A nonzero value enters the first cell as a fresh search.
    assign w_tok[0] = '{vld: w_in_acc && !w_is_end, st: sdr_pkg::ST_SEARCH, val: i_value};
    assign w_pos[0] = '0;

    // Each cell compares its kept value against the passing search. The first
    // empty cell takes the value; a match marks the search as a repeat.
    for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
        sdr_cell #(
            .CELL_IDX(k),
            .IDX_W   (IDX_W),
            .CNT_W   (CNT_W)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_count(r_count),
            .i_tok  (w_tok[k]),
            .i_pos  (w_pos[k]),
            .o_tok  (w_tok[k+1]),
            .o_pos  (w_pos[k+1])
        );
    end

    // Control: list state, busy flag and output valid. The kept count
    // changes only when a search leaves the row or a zero request clears it, so
    // every cell sees a steady count while the search walks past.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_busy    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_out_acc) begin
                r_out_vld <= 1'b0;
            end
            if (w_in_acc && w_is_end) begin
                r_count   <= '0;
                r_ovf     <= 1'b0;
                r_out_vld <= 1'b1;
            end else if (w_in_acc) begin
                r_busy <= 1'b1;
            end
            if (w_tok[MAX_ENTRIES].vld) begin
                r_busy <= 1'b0;
                case (w_tok[MAX_ENTRIES].st)
                    sdr_pkg::ST_NEW: begin
                        r_count   <= CNT_W'(w_pos[MAX_ENTRIES]) + CNT_W'(1);
                        r_out_vld <= 1'b1;
                    end
                    sdr_pkg::ST_SEARCH: begin
                        // The search passed every kept entry without a match
                        // and found no free cell: the store is full.
                        r_ovf <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_is_end) begin
            r_kind      <= sdr_pkg::KIND_END;
            r_value_res <= '0;
            r_count_out <= sdr_pkg::COUNT_W'(r_count);
            r_ovf_out   <= r_ovf;
        end else if (w_exit_new) begin
            r_kind      <= sdr_pkg::KIND_NEW;
            r_value_res <= w_tok[MAX_ENTRIES].val;
            r_count_out <= sdr_pkg::COUNT_W'(w_pos[MAX_ENTRIES]);
            r_ovf_out   <= 1'b0;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_kind      = r_kind;
    assign o_value_res = r_value_res;
    assign o_count     = r_count_out;
    assign o_overflow  = r_ovf_out;

    // A search only leaves the row while the block is marked busy.
    `SDR_ASSERT_IMPLY(a_exit_while_busy, i_clk, i_rst_n, w_tok[MAX_ENTRIES].vld, r_busy)
    // A newly kept value always lands in the first free entry.
    `SDR_ASSERT_IMPLY(a_new_at_count, i_clk, i_rst_n, w_exit_new, CNT_W'(w_pos[MAX_ENTRIES]) == r_count)
    // The kept count never passes the store size.
    `SDR_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= MaxCnt)

endmodule
